[design/fpdf_pkg.sv]
// fpdf_pkg: shared types, register indexes and constants of the point decode filter
package fpdf_pkg;

  // field widths
  localparam int FREQ_W = 16;
  localparam int LINE_W = 8;
  localparam int TAG_W  = 8;
  localparam int Q_W    = 18;
  localparam int ROW_W  = 9;
  localparam int TOL_W  = 16;
  localparam int LIM_W  = 17;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_SCALE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE       = 3'd6;

  // register reset values
  localparam logic [FREQ_W-1:0] RST_FREQ_LIMIT      = 16'd491;
  localparam logic [FREQ_W-1:0] RST_DIST_OFFSET     = 16'd170;
  localparam logic [FREQ_W-1:0] RST_DIST_SCALE      = 16'd12000;
  localparam logic [FREQ_W-1:0] RST_VEL_SCALE       = 16'd24800;
  localparam logic [TOL_W-1:0]  RST_MATCH_TOLERANCE = 16'd205;
  localparam logic [LIM_W-1:0]  RST_MAX_SPEED       = 17'd8192;
  localparam logic [LIM_W-1:0]  RST_MAX_RANGE       = 17'd40960;

  // arithmetic shifts of the two products
  localparam int DIST_SHIFT = 12;
  localparam int VEL_SHIFT  = 8;

  // configuration seen by the arithmetic front end
  typedef struct packed {
    logic [FREQ_W-1:0] freq_limit;
    logic [FREQ_W-1:0] dist_offset;
    logic [FREQ_W-1:0] dist_scale;
    logic [FREQ_W-1:0] vel_scale;
  } front_cfg_t;

  // decoded point handed from the front end to the filter
  typedef struct packed {
    logic                has_range;
    logic signed [Q_W-1:0] distance_q;
    logic signed [Q_W-1:0] velocity_q;
    logic [ROW_W-1:0]    ring_row;
  } point_t;

  // laser row offset per channel code
  function automatic logic [ROW_W-1:0] chan_offset(input logic [1:0] chan);
    logic [ROW_W-1:0] off;
    case (chan)
      2'd0:    off = 9'd33;
      2'd1:    off = 9'd21;
      2'd2:    off = 9'd8;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

[design/fpdf_if.sv]
// fpdf_if: valid/ready channel interfaces for point records and filter results

interface fpdf_in_if;
  logic                         valid;
  logic                         ready;
  logic [fpdf_pkg::FREQ_W-1:0]  freq_a;
  logic [fpdf_pkg::LINE_W-1:0]  line_index;
  logic [fpdf_pkg::TAG_W-1:0]   tag_a;
  logic [fpdf_pkg::FREQ_W-1:0]  freq_b;
  logic [fpdf_pkg::TAG_W-1:0]   tag_b;

  modport source (output valid, freq_a, line_index, tag_a, freq_b, tag_b, input ready);
  modport sink   (input valid, freq_a, line_index, tag_a, freq_b, tag_b, output ready);
endinterface

interface fpdf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              keep;
  logic                              has_range;
  logic signed [fpdf_pkg::Q_W-1:0]   distance_q;
  logic signed [fpdf_pkg::Q_W-1:0]   velocity_q;
  logic [fpdf_pkg::ROW_W-1:0]        ring_row;

  modport source (output valid, keep, has_range, distance_q, velocity_q, ring_row,
                  input ready);
  modport sink   (input valid, keep, has_range, distance_q, velocity_q, ring_row,
                  output ready);
endinterface

[design/fmcw_point_decode_filter_core.sv]
// fmcw_point_decode_filter_core: lidar point decode with history consistency filter
//
// in_ch carries one point record per transaction (two beat frequencies, line index
// and two tag bytes); out_ch returns one result per record, in order: keep flag,
// range flag, q10 distance and velocity, and laser row.
// A record passes through the stages in order: decode and sum, scale multiply,
// shift and saturate, then the history compare that loads the output register.
// A new record can be taken every cycle while in_ch.ready is high; the history
// row of HISTORY_DEPTH cells is compared in the same cycle as the output
// register loads and shifted at that load when the distance is nonzero, so each
// record sees the history left by the records before it.
// When the receiver stalls the output register holds, the pipeline stages fill
// behind it and in_ch.ready drops only once every stage is occupied.
// Synchronous active-low reset empties the pipeline, clears the history cells to
// zero and loads the register defaults; configuration writes through cfg_we,
// cfg_index and cfg_wdata take effect at the next clock and are meant for an
// idle block. Writes to an unused index are dropped.
module fmcw_point_decode_filter_core #(
  parameter int HISTORY_DEPTH = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fpdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  fpdf_in_if.sink                          in_ch,
  fpdf_out_if.source                       out_ch
);

  // configuration registers
  logic [fpdf_pkg::FREQ_W-1:0] freq_limit_r, dist_offset_r, dist_scale_r, vel_scale_r;
  logic [fpdf_pkg::TOL_W-1:0]  match_tol_r;
  logic [fpdf_pkg::LIM_W-1:0]  max_speed_r, max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_limit_r  <= fpdf_pkg::RST_FREQ_LIMIT;
      dist_offset_r <= fpdf_pkg::RST_DIST_OFFSET;
      dist_scale_r  <= fpdf_pkg::RST_DIST_SCALE;
      vel_scale_r   <= fpdf_pkg::RST_VEL_SCALE;
      match_tol_r   <= fpdf_pkg::RST_MATCH_TOLERANCE;
      max_speed_r   <= fpdf_pkg::RST_MAX_SPEED;
      max_range_r   <= fpdf_pkg::RST_MAX_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        fpdf_pkg::CFG_FREQ_LIMIT:      freq_limit_r  <= cfg_wdata[15:0];
        fpdf_pkg::CFG_DIST_OFFSET:     dist_offset_r <= cfg_wdata[15:0];
        fpdf_pkg::CFG_DIST_SCALE:      dist_scale_r  <= cfg_wdata[15:0];
        fpdf_pkg::CFG_VEL_SCALE:       vel_scale_r   <= cfg_wdata[15:0];
        fpdf_pkg::CFG_MATCH_TOLERANCE: match_tol_r   <= cfg_wdata[15:0];
        fpdf_pkg::CFG_MAX_SPEED:       max_speed_r   <= cfg_wdata;
        fpdf_pkg::CFG_MAX_RANGE:       max_range_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fpdf_pkg::front_cfg_t front_cfg;
  assign front_cfg.freq_limit  = freq_limit_r;
  assign front_cfg.dist_offset = dist_offset_r;
  assign front_cfg.dist_scale  = dist_scale_r;
  assign front_cfg.vel_scale   = vel_scale_r;

  // arithmetic front end
  logic             pt_valid, pt_ready;
  fpdf_pkg::point_t pt;

  fpdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (front_cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .freq_a     (in_ch.freq_a),
    .line_index (in_ch.line_index),
    .tag_a      (in_ch.tag_a),
    .freq_b     (in_ch.freq_b),
    .tag_b      (in_ch.tag_b),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt         (pt)
  );

  // output load and history shift
  logic out_valid_r;
  logic load, hist_shift;

  assign pt_ready   = !out_valid_r || out_ch.ready;
  assign load       = pt_valid && pt_ready;
  assign hist_shift = load && (pt.distance_q != '0);

  // history row: cell 0 takes the new distance, each cell hands on to the next
  logic signed [fpdf_pkg::Q_W-1:0] chain [HISTORY_DEPTH+1];
  logic [HISTORY_DEPTH-1:0]        match;

  assign chain[0] = pt.distance_q;

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    fpdf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (hist_shift),
      .dist_in   (chain[g]),
      .probe     (pt.distance_q),
      .tolerance (match_tol_r),
      .dist_out  (chain[g+1]),
      .match     (match[g])
    );
  end

  // at least two matches; a single cell counts its match twice
  logic                           enough;
  logic [fpdf_pkg::Q_W-1:0]       vmag;
  logic                           keep_nxt;

  always_comb begin
    if (HISTORY_DEPTH == 1) begin
      enough = match[0];
    end else begin
      enough = (match & (match - HISTORY_DEPTH'(1))) != '0;
    end
    vmag     = pt.velocity_q[fpdf_pkg::Q_W-1] ? fpdf_pkg::Q_W'(-pt.velocity_q)
                                               : fpdf_pkg::Q_W'(pt.velocity_q);
    keep_nxt = (pt.distance_q != '0) && enough &&
               ({1'b0, vmag} < {2'b00, max_speed_r}) &&
               (pt.distance_q < $signed({1'b0, max_range_r}));
  end

  // output register
  logic                            keep_r, has_range_r;
  logic signed [fpdf_pkg::Q_W-1:0] dist_r, vel_r;
  logic [fpdf_pkg::ROW_W-1:0]      row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pt_ready) begin
      out_valid_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keep_r      <= keep_nxt;
      has_range_r <= pt.has_range;
      dist_r      <= pt.distance_q;
      vel_r       <= pt.velocity_q;
      row_r       <= pt.ring_row;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = keep_r;
  assign out_ch.has_range  = has_range_r;
  assign out_ch.distance_q = dist_r;
  assign out_ch.velocity_q = vel_r;
  assign out_ch.ring_row   = row_r;

  // kept point carries a valid nonzero distance
  a_keep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.keep |-> out_ch.has_range && (out_ch.distance_q != '0))
    else $error("kept point without valid distance");

  // no range means zero distance
  a_norange_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.has_range |-> out_ch.distance_q == '0)
    else $error("distance present without range");

  // history moves only on a loaded nonzero distance
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !hist_shift |=> $stable(chain[1]))
    else $error("history changed without a nonzero point");

  // newest history entry is the distance just delivered
  a_hist_newest: assert property (@(posedge clk) disable iff (!rst_n)
    hist_shift |=> chain[1] == out_ch.distance_q)
    else $error("history entry differs from delivered distance");

endmodule

[design/fpdf_cell.sv]
// fpdf_cell: one history cell holding a past distance and matching the probe against it
module fpdf_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift_en,
  input  logic signed [fpdf_pkg::Q_W-1:0]   dist_in,
  input  logic signed [fpdf_pkg::Q_W-1:0]   probe,
  input  logic [fpdf_pkg::TOL_W-1:0]        tolerance,
  output logic signed [fpdf_pkg::Q_W-1:0]   dist_out,
  output logic                              match
);

  logic signed [fpdf_pkg::Q_W-1:0] hist_r;
  logic signed [fpdf_pkg::Q_W:0]   delta;
  logic [fpdf_pkg::Q_W:0]          mag;

  // take the neighbor's distance when the row moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (shift_en) begin
      hist_r <= dist_in;
    end
  end

  // absolute distance difference against tolerance
  always_comb begin
    delta = (fpdf_pkg::Q_W+1)'(probe) - (fpdf_pkg::Q_W+1)'(hist_r);
    mag   = delta[fpdf_pkg::Q_W] ? (fpdf_pkg::Q_W+1)'(-delta) : (fpdf_pkg::Q_W+1)'(delta);
    match = mag < {{(fpdf_pkg::Q_W+1-fpdf_pkg::TOL_W){1'b0}}, tolerance};
  end

  assign dist_out = hist_r;

endmodule

[design/fpdf_front.sv]
// fpdf_front: three-stage decode, scale and saturate pipeline for distance and velocity
module fpdf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpdf_pkg::front_cfg_t          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fpdf_pkg::FREQ_W-1:0]   freq_a,
  input  logic [fpdf_pkg::LINE_W-1:0]   line_index,
  input  logic [fpdf_pkg::TAG_W-1:0]    tag_a,
  input  logic [fpdf_pkg::FREQ_W-1:0]   freq_b,
  input  logic [fpdf_pkg::TAG_W-1:0]    tag_b,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output fpdf_pkg::point_t              pt
);

  localparam int SUM_W  = 22;
  localparam int DIFF_W = 17;
  localparam int DP_W   = 39;
  localparam int VP_W   = 34;
  localparam logic signed [DP_W-1:0] DQ_MAX = 39'sd131071;
  localparam logic signed [DP_W-1:0] DQ_MIN = -39'sd131072;
  localparam logic signed [VP_W-1:0] VQ_MAX = 34'sd131071;
  localparam logic signed [VP_W-1:0] VQ_MIN = -34'sd131072;

  // stage valids
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  // stage 1 payload
  logic signed [SUM_W-1:0]          s1_sum_r;
  logic signed [DIFF_W-1:0]         s1_diff_r;
  logic                             s1_has_r;
  logic [fpdf_pkg::ROW_W-1:0]       s1_row_r;
  // stage 2 payload
  logic signed [DP_W-1:0]           s2_dprod_r;
  logic signed [VP_W-1:0]           s2_vprod_r;
  logic                             s2_has_r;
  logic [fpdf_pkg::ROW_W-1:0]       s2_row_r;
  // stage 3 payload
  fpdf_pkg::point_t                 s3_pt_r;

  logic [fpdf_pkg::FREQ_W-1:0]      up_raw, down_raw, up_f, down_f;
  logic [fpdf_pkg::FREQ_W:0]        fsum;
  logic signed [SUM_W-1:0]          sum_nxt;
  logic signed [DIFF_W-1:0]         diff_nxt;
  logic signed [DP_W-1:0]           dsh;
  logic signed [VP_W-1:0]           vsh;
  logic signed [fpdf_pkg::Q_W-1:0]  dsat, vsat;

  // pipeline flow
  assign adv3     = !v3_r || pt_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // chirp assignment by parity and band limit
  always_comb begin
    up_raw   = '0;
    down_raw = '0;
    if (!tag_a[0] && tag_b[0]) begin
      down_raw = freq_a;
      up_raw   = freq_b;
    end else if (tag_a[0] && !tag_b[0]) begin
      up_raw   = freq_a;
      down_raw = freq_b;
    end
    up_f     = (up_raw > cfg.freq_limit) ? '0 : up_raw;
    down_f   = (down_raw > cfg.freq_limit) ? '0 : down_raw;
    fsum     = {1'b0, up_f} + {1'b0, down_f};
    sum_nxt  = $signed({1'b0, fsum, 4'b0000}) - $signed({6'b0, cfg.dist_offset});
    diff_nxt = $signed({1'b0, down_f}) - $signed({1'b0, up_f});
  end

  // stage 1: decoded sum and difference
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_sum_r  <= sum_nxt;
      s1_diff_r <= diff_nxt;
      s1_has_r  <= (up_f != '0) && (down_f != '0);
      s1_row_r  <= {1'b0, line_index} + fpdf_pkg::chan_offset(tag_a[7:6]);
    end
  end

  // stage 2: scale products
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      s2_dprod_r <= DP_W'(s1_sum_r) * DP_W'($signed({1'b0, cfg.dist_scale}));
      s2_vprod_r <= VP_W'(s1_diff_r) * VP_W'($signed({1'b0, cfg.vel_scale}));
      s2_has_r   <= s1_has_r;
      s2_row_r   <= s1_row_r;
    end
  end

  // floor shift and saturation to q10
  always_comb begin
    dsh = s2_dprod_r >>> fpdf_pkg::DIST_SHIFT;
    vsh = s2_vprod_r >>> fpdf_pkg::VEL_SHIFT;
    if (dsh > DQ_MAX)      dsat = fpdf_pkg::Q_W'(DQ_MAX);
    else if (dsh < DQ_MIN) dsat = fpdf_pkg::Q_W'(DQ_MIN);
    else                   dsat = dsh[fpdf_pkg::Q_W-1:0];
    if (vsh > VQ_MAX)      vsat = fpdf_pkg::Q_W'(VQ_MAX);
    else if (vsh < VQ_MIN) vsat = fpdf_pkg::Q_W'(VQ_MIN);
    else                   vsat = vsh[fpdf_pkg::Q_W-1:0];
  end

  // stage 3: finished point
  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      s3_pt_r.has_range  <= s2_has_r;
      s3_pt_r.distance_q <= s2_has_r ? dsat : '0;
      s3_pt_r.velocity_q <= vsat;
      s3_pt_r.ring_row   <= s2_row_r;
    end
  end

  assign pt_valid = v3_r;
  assign pt       = s3_pt_r;

endmodule
